// ----- rtl/lstc_pkg.sv -----
// Shared types and codes for the LRU sector tag cache.
`timescale 1ns / 1ps

package lstc_pkg;

    localparam int TICK_W    = 32;
    localparam int SIZE_W    = 14;
    localparam int MASK_W    = 8;
    localparam int OWNER_IN_W = 8;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_INVAL  = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_MISS    = 3'd1,
        ST_FILL    = 3'd2,
        ST_REFRESH = 3'd3,
        ST_REJECT  = 3'd4,
        ST_INVAL   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [OWNER_IN_W-1:0]  owner_id;
        logic [15:0]            file_index;
        logic [15:0]            blk_off;
        logic [15:0]            sector_bytes;
    } t_req;

    typedef struct packed {
        logic [2:0]        status;
        logic [2:0]        way;
        logic [SIZE_W-1:0] stored_size;
        logic [MASK_W-1:0] cleared_mask;
    } t_rsp;

endpackage

// ----- rtl/lstc_scan.sv -----
// Shared way comparator and running scan results (first hit, first free, oldest tick).
`timescale 1ns / 1ps

module lstc_scan import lstc_pkg::*; #(
    parameter int WAYS    = 8,
    parameter int OWNER_W = 8,
    localparam int IW     = $clog2(WAYS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_step,
    input  logic [IW-1:0]      i_idx,
    input  logic               i_way_valid,
    input  logic [OWNER_W-1:0] i_way_owner,
    input  logic [15:0]        i_way_file_index,
    input  logic [15:0]        i_way_blk_off,
    input  logic [SIZE_W-1:0]  i_way_size,
    input  logic [TICK_W-1:0]  i_way_tick,
    input  logic [OWNER_W-1:0] i_req_owner,
    input  logic [15:0]        i_req_file_index,
    input  logic [15:0]        i_req_blk_off,
    output logic               o_owner_eq,
    output logic               o_hit,
    output logic [IW-1:0]      o_hit_way,
    output logic [SIZE_W-1:0]  o_hit_size,
    output logic               o_free,
    output logic [IW-1:0]      o_free_way,
    output logic [IW-1:0]      o_lru_way,
    output logic [MASK_W-1:0]  o_cleared_mask
);

    logic              r_hit;
    logic [IW-1:0]     r_hit_way;
    logic [SIZE_W-1:0] r_hit_size;
    logic              r_free;
    logic [IW-1:0]     r_free_way;
    logic [TICK_W-1:0] r_least;
    logic [IW-1:0]     r_lru_way;
    logic [MASK_W-1:0] r_mask;

    logic tag_eq;

    assign o_owner_eq = (i_way_owner == i_req_owner);
    assign tag_eq = o_owner_eq && (i_way_file_index == i_req_file_index)
                    && (i_way_blk_off == i_req_blk_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_least   <= '1;
            r_lru_way <= '0;
            r_mask    <= '0;
        end else if (i_step) begin
            if (i_way_valid && tag_eq && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (!i_way_valid && !r_free) begin
                r_free <= 1'b1;
            end
            // strict compare: the first of equal oldest ticks wins
            if (i_way_valid && (i_way_tick < r_least)) begin
                r_least   <= i_way_tick;
                r_lru_way <= i_idx;
            end
            // only ways 0..7 are reported
            for (int b = 0; b < MASK_W; b++) begin
                if (i_way_valid && o_owner_eq && (32'(i_idx) == b)) begin
                    r_mask[b] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (i_way_valid && tag_eq && !r_hit) begin
                r_hit_way  <= i_idx;
                r_hit_size <= i_way_size;
            end
            if (!i_way_valid && !r_free) begin
                r_free_way <= i_idx;
            end
        end
    end

    assign o_hit          = r_hit;
    assign o_hit_way      = r_hit_way;
    assign o_hit_size     = r_hit_size;
    assign o_free         = r_free;
    assign o_free_way     = r_free_way;
    assign o_lru_way      = r_lru_way;
    assign o_cleared_mask = r_mask;

endmodule

// ----- rtl/lru_sector_tag_cache_core.sv -----
// Top level: tag store, scan sequencer and result register of the LRU sector tag cache.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// --------  ---------  ----------------------------  ----------------------------
// request   in         i_in_valid / o_in_ready       i_in_data  (t_req)
// response  out        o_out_valid / i_out_ready     o_out_data (t_rsp)
//
// Sequence: lookup, insert and invalidate step through the ways one way a cycle through
//   the shared comparator, then commit in S_DONE and return to S_IDLE to take the next
//   request; the result is registered at commit. Oversize inserts and the unused
//   command skip the scan and go straight to S_DONE to commit.
// Reset: synchronous, active low; clears valid bits, tick counter, FSM, output valid.
// Stalls: a new request is taken while a result waits; the commit cycle holds
//   until the result register is free.
module lru_sector_tag_cache_core import lstc_pkg::*; #(
    parameter int WAYS           = 8,
    parameter int MAX_SLOT_BYTES = 8192,
    parameter int OWNER_BITS     = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    localparam int IW      = $clog2(WAYS);
    localparam int OWNER_W = (OWNER_BITS < OWNER_IN_W) ? OWNER_BITS : OWNER_IN_W;
    localparam logic [IW-1:0] LAST_WAY = IW'(WAYS - 1);

    // tag store; payload fields carry no reset, only the valid bits do
    logic              r_way_valid        [WAYS];
    logic [OWNER_W-1:0] r_way_owner       [WAYS];
    logic [15:0]       r_way_file_index   [WAYS];
    logic [15:0]       r_way_blk_off      [WAYS];
    logic [SIZE_W-1:0] r_way_size         [WAYS];
    logic [TICK_W-1:0] r_way_tick         [WAYS];
    logic [TICK_W-1:0] r_use_clock;

    t_state  r_state, n_state;
    t_req    r_req;
    logic [IW-1:0] r_idx;
    logic    r_out_valid;
    t_rsp    r_out;

    logic    accept;
    logic    scan_step;
    logic    commit;
    logic    out_free;
    logic    oversize;
    logic    skip_scan;

    logic              owner_eq;
    logic              hit;
    logic [IW-1:0]     hit_way;
    logic [SIZE_W-1:0] hit_size;
    logic              free;
    logic [IW-1:0]     free_way;
    logic [IW-1:0]     lru_way;
    logic [MASK_W-1:0] cleared_mask;

    t_rsp              rsp;
    logic              wr_tag;
    logic              wr_tick;
    logic [IW-1:0]     wr_way;
    logic [TICK_W-1:0] next_tick;

    assign accept    = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign oversize  = (r_req.sector_bytes > 16'(MAX_SLOT_BYTES));
    assign skip_scan = (i_in_data.cmd == CMD_RSVD) ||
                       ((i_in_data.cmd == CMD_INSERT) &&
                        (i_in_data.sector_bytes > 16'(MAX_SLOT_BYTES)));
    assign next_tick = r_use_clock + 32'd1;

    // shared comparator over the way at r_idx
    lstc_scan #(
        .WAYS    (WAYS),
        .OWNER_W (OWNER_W)
    ) u_scan (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (accept),
        .i_step             (scan_step),
        .i_idx              (r_idx),
        .i_way_valid        (r_way_valid[r_idx]),
        .i_way_owner        (r_way_owner[r_idx]),
        .i_way_file_index   (r_way_file_index[r_idx]),
        .i_way_blk_off      (r_way_blk_off[r_idx]),
        .i_way_size         (r_way_size[r_idx]),
        .i_way_tick         (r_way_tick[r_idx]),
        .i_req_owner        (r_req.owner_id[OWNER_W-1:0]),
        .i_req_file_index   (r_req.file_index),
        .i_req_blk_off      (r_req.blk_off),
        .o_owner_eq         (owner_eq),
        .o_hit              (hit),
        .o_hit_way          (hit_way),
        .o_hit_size         (hit_size),
        .o_free             (free),
        .o_free_way         (free_way),
        .o_lru_way          (lru_way),
        .o_cleared_mask     (cleared_mask)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = skip_scan ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_WAY) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        o_in_ready = 1'b0;
        scan_step  = 1'b0;
        commit     = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_SCAN:  scan_step  = 1'b1;
            S_DONE:  commit     = out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

    // result and tag-store write selection at commit
    always_comb begin
        rsp     = '0;
        rsp.status = ST_MISS;
        wr_tag  = 1'b0;
        wr_tick = 1'b0;
        wr_way  = hit_way;
        priority if (r_req.cmd == CMD_LOOKUP) begin
            if (hit) begin
                rsp.status      = ST_HIT;
                rsp.way         = 3'(hit_way);
                rsp.stored_size = hit_size;
                wr_tick         = 1'b1;
            end
        end else if (r_req.cmd == CMD_INSERT) begin
            if (oversize) begin
                rsp.status = ST_REJECT;
            end else begin
                // refresh a match, else first free way, else oldest tick
                if (hit) begin
                    rsp.status = ST_REFRESH;
                    wr_way     = hit_way;
                end else if (free) begin
                    rsp.status = ST_FILL;
                    wr_way     = free_way;
                end else begin
                    rsp.status = ST_FILL;
                    wr_way     = lru_way;
                end
                wr_tag          = 1'b1;
                wr_tick         = 1'b1;
                rsp.way         = 3'(wr_way);
                rsp.stored_size = r_req.sector_bytes[SIZE_W-1:0];
            end
        end else if (r_req.cmd == CMD_INVAL) begin
            rsp.status       = ST_INVAL;
            rsp.cleared_mask = cleared_mask;
        end else begin
            rsp.status = ST_MISS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_use_clock <= '0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (commit && wr_tick) begin
                r_use_clock <= next_tick;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_data;
        end
        if (commit) begin
            r_out <= rsp;
        end
    end

    // way index for the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || accept) begin
            r_idx <= '0;
        end else if (scan_step && (r_idx != LAST_WAY)) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    // valid bits: cleared on owner match during an invalidate scan, set on insert
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WAYS; w++) begin
                r_way_valid[w] <= 1'b0;
            end
        end else if (scan_step && (r_req.cmd == CMD_INVAL) && owner_eq) begin
            r_way_valid[r_idx] <= 1'b0;
        end else if (commit && wr_tag) begin
            r_way_valid[wr_way] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit && wr_tag) begin
            r_way_owner[wr_way]        <= r_req.owner_id[OWNER_W-1:0];
            r_way_file_index[wr_way]   <= r_req.file_index;
            r_way_blk_off[wr_way]      <= r_req.blk_off;
            r_way_size[wr_way]         <= r_req.sector_bytes[SIZE_W-1:0];
        end
        if (commit && wr_tick) begin
            r_way_tick[wr_way] <= next_tick;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
